### design/rrfb_pkg.sv
// Shared constants and types for the rounded rectangle fill and blend pipeline.
package rrfb_pkg;

    localparam int CH_W       = 8;
    localparam int RECT_W     = 13;
    localparam int RADIUS_W   = 12;
    localparam int EXC_W      = RADIUS_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DIV_QUO_W  = 8;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_NUM_W  = DIV_DEN_W + DIV_QUO_W;

    // floor(x / 255) equals (x * RECIP_255) >> RECIP_SHIFT for every x up to 255 * 255.
    localparam int RECIP_255   = 32897;
    localparam int RECIP_SHIFT = 23;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT     = 3'd0,
        CFG_RECT_TOP      = 3'd1,
        CFG_RECT_WIDTH    = 3'd2,
        CFG_RECT_HEIGHT   = 3'd3,
        CFG_CORNER_RADIUS = 3'd4,
        CFG_FILL_COLOR    = 3'd5
    } t_cfg_idx;

endpackage

### design/rrfb_divider.sv
// Pipelined restoring divider, one quotient bit per register stage.
module rrfb_divider (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [rrfb_pkg::DIV_NUM_W-1:0] i_num,
    input  logic [rrfb_pkg::DIV_DEN_W-1:0] i_den,
    output logic [rrfb_pkg::DIV_QUO_W-1:0] o_quo
);
    import rrfb_pkg::*;

    logic [DIV_NUM_W-1:0] r_rem [DIV_QUO_W-1];
    logic [DIV_DEN_W-1:0] r_dn  [DIV_QUO_W-1];
    logic [DIV_QUO_W-1:0] r_q   [DIV_QUO_W];

    for (genvar k = 0; k < DIV_QUO_W; k++) begin : g_stage
        localparam int SH = DIV_QUO_W - 1 - k;
        logic [DIV_NUM_W-1:0] rem_in;
        logic [DIV_NUM_W-1:0] sub;
        logic [DIV_DEN_W-1:0] dn_in;
        logic [DIV_QUO_W-1:0] q_in;
        logic                 take;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign dn_in  = i_den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign dn_in  = r_dn[k-1];
            assign q_in   = r_q[k-1];
        end

        assign sub  = DIV_NUM_W'(dn_in) << SH;
        assign take = (rem_in >= sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k] <= {q_in[DIV_QUO_W-2:0], take};
            end
        end

        // The last stage only needs its quotient bit.
        if (k < DIV_QUO_W - 1) begin : g_keep
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= take ? (rem_in - sub) : rem_in;
                    r_dn[k]  <= dn_in;
                end
            end
        end
    end

    assign o_quo = r_q[DIV_QUO_W-1];

endmodule

### design/rounded_rect_fill_blend.sv
// Top level of the rounded rectangle coverage test and straight-alpha over blend.
// Throughput: one pixel word per clock; the whole pipeline holds while the output is stalled.
// The pipeline is made of three arithmetic stages, eight divider stages and the output register.
// Reset clears the configuration registers to zero and every valid bit; no clearing pass.
module rounded_rect_fill_blend #(
    parameter int COORD_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [rrfb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rrfb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [COORD_BITS-1:0]           i_pixel_x,
    input  logic [COORD_BITS-1:0]           i_pixel_y,
    input  logic [rrfb_pkg::CH_W-1:0]       i_dest_red,
    input  logic [rrfb_pkg::CH_W-1:0]       i_dest_green,
    input  logic [rrfb_pkg::CH_W-1:0]       i_dest_blue,
    input  logic [rrfb_pkg::CH_W-1:0]       i_dest_alpha,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [rrfb_pkg::CH_W-1:0]       o_out_red,
    output logic [rrfb_pkg::CH_W-1:0]       o_out_green,
    output logic [rrfb_pkg::CH_W-1:0]       o_out_blue,
    output logic [rrfb_pkg::CH_W-1:0]       o_out_alpha,
    output logic                            o_covered
);
    import rrfb_pkg::*;

    localparam int SW = (COORD_BITS + 3 > 17) ? COORD_BITS + 3 : 17;
    localparam int SQ_W = 2 * EXC_W;

    typedef struct packed {
        logic                      valid;
        logic                      cov;
        logic                      pass;
        logic [2:0][CH_W-1:0]      dst;
        logic [CH_W-1:0]           da;
        logic [CH_W-1:0]           alpha;
    } t_side;

    // Configuration registers.
    logic signed [RECT_W-1:0]   r_rect_left;
    logic signed [RECT_W-1:0]   r_rect_top;
    logic        [RECT_W-1:0]   r_rect_width;
    logic        [RECT_W-1:0]   r_rect_height;
    logic        [RADIUS_W-1:0] r_corner_radius;
    logic        [CFG_DATA_W-1:0] r_fill_color;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rect_left     <= '0;
            r_rect_top      <= '0;
            r_rect_width    <= '0;
            r_rect_height   <= '0;
            r_corner_radius <= '0;
            r_fill_color    <= '0;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_RECT_LEFT:     r_rect_left     <= signed'(i_cfg_data[RECT_W-1:0]);
                CFG_RECT_TOP:      r_rect_top      <= signed'(i_cfg_data[RECT_W-1:0]);
                CFG_RECT_WIDTH:    r_rect_width    <= i_cfg_data[RECT_W-1:0];
                CFG_RECT_HEIGHT:   r_rect_height   <= i_cfg_data[RECT_W-1:0];
                CFG_CORNER_RADIUS: r_corner_radius <= i_cfg_data[RADIUS_W-1:0];
                CFG_FILL_COLOR:    r_fill_color    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    logic [CH_W-1:0] fill_src [3];
    logic [CH_W-1:0] fill_a;
    assign fill_src[0] = r_fill_color[31:24];
    assign fill_src[1] = r_fill_color[23:16];
    assign fill_src[2] = r_fill_color[15:8];
    assign fill_a      = r_fill_color[7:0];

    // One enable for the whole pipeline: it moves unless a finished word is held.
    logic en;
    logic r_out_valid;
    assign o_stall = r_out_valid && i_stall;
    assign en      = !o_stall;

    function automatic logic [EXC_W-1:0] axis_excess(
        input logic signed [SW-1:0] c,
        input logic signed [SW-1:0] lo,
        input logic signed [SW-1:0] hi,
        input logic signed [SW-1:0] r2
    );
        logic signed [SW-1:0] lo_r;
        logic signed [SW-1:0] hi_r;
        logic signed [SW-1:0] diff;
        lo_r = lo + r2;
        hi_r = hi - r2;
        if (c < lo_r) begin
            diff = lo_r - c;
        end else if (c > hi_r) begin
            diff = c - hi_r;
        end else begin
            diff = '0;
        end
        // Inside the rectangle the excess never exceeds the doubled radius.
        return diff[EXC_W-1:0];
    endfunction

    // Stage 1: doubled-coordinate bounds, corner excess and the alpha weights.
    logic signed [SW-1:0]   s1_cx, s1_cy, s1_l2, s1_r2, s1_t2, s1_b2, s1_c2;
    logic signed [SW-2:0]   s1_re, s1_be;
    logic                   s1_in_rect;
    logic [CH_W-1:0]        s1_inv_a;
    logic [2*CH_W-1:0]      s1_wd;

    always_comb begin
        s1_cx = signed'({{(SW-COORD_BITS-1){1'b0}}, i_pixel_x, 1'b1});
        s1_cy = signed'({{(SW-COORD_BITS-1){1'b0}}, i_pixel_y, 1'b1});
        s1_l2 = signed'({{(SW-RECT_W-1){r_rect_left[RECT_W-1]}}, r_rect_left, 1'b0});
        s1_t2 = signed'({{(SW-RECT_W-1){r_rect_top[RECT_W-1]}}, r_rect_top, 1'b0});
        s1_re = signed'({{(SW-1-RECT_W){r_rect_left[RECT_W-1]}}, r_rect_left})
              + signed'({{(SW-1-RECT_W){1'b0}}, r_rect_width});
        s1_be = signed'({{(SW-1-RECT_W){r_rect_top[RECT_W-1]}}, r_rect_top})
              + signed'({{(SW-1-RECT_W){1'b0}}, r_rect_height});
        s1_r2 = signed'({s1_re, 1'b0});
        s1_b2 = signed'({s1_be, 1'b0});
        s1_c2 = signed'({{(SW-RADIUS_W-1){1'b0}}, r_corner_radius, 1'b0});
        s1_in_rect = (s1_cx >= s1_l2) && (s1_cx < s1_r2) && (s1_cy >= s1_t2) && (s1_cy < s1_b2);
        s1_inv_a = 8'hFF - fill_a;
        s1_wd    = {8'd0, i_dest_alpha} * {8'd0, s1_inv_a};
    end

    logic                   r1_valid;
    logic                   r1_in_rect;
    logic [EXC_W-1:0]       r1_dx, r1_dy;
    logic [2*CH_W-1:0]      r1_wd;
    logic [2*CH_W-1:0]      r1_sa [3];
    logic [CH_W-1:0]        r1_d  [3];
    logic [CH_W-1:0]        r1_da;

    // Stage 2 values.
    logic                   r2_valid;
    logic                   r2_in_rect;
    logic [SQ_W-1:0]        r2_dx2, r2_dy2, r2_c2sq;
    logic [DIV_NUM_W-1:0]   r2_num_s [3];
    logic [DIV_NUM_W-1:0]   r2_num_d [3];
    logic [DIV_DEN_W-1:0]   r2_den;
    logic [CH_W-1:0]        r2_d [3];
    logic [CH_W-1:0]        r2_da;

    // Stage 3 values.
    logic                   r3_valid;
    logic                   r3_cov;
    logic                   r3_pass;
    logic [DIV_NUM_W-1:0]   r3_num [3];
    logic [DIV_DEN_W-1:0]   r3_den;
    logic [CH_W-1:0]        r3_alpha;
    logic [CH_W-1:0]        r3_d [3];
    logic [CH_W-1:0]        r3_da;

    logic [EXC_W-1:0]       s2_c2;
    logic [SQ_W:0]          s3_dist;
    logic                   s3_cov;
    logic [31:0]            s3_aprod;

    assign s2_c2    = {r_corner_radius, 1'b0};
    assign s3_dist  = {1'b0, r2_dx2} + {1'b0, r2_dy2};
    assign s3_cov   = r2_in_rect && (s3_dist <= {1'b0, r2_c2sq});
    assign s3_aprod = 32'(r2_den) * 32'(RECIP_255);

    t_side r_side [DIV_QUO_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            for (int k = 0; k < DIV_QUO_W; k++) begin
                r_side[k].valid <= 1'b0;
            end
        end else if (en) begin
            // Stage 1.
            r1_valid   <= i_valid;
            r1_in_rect <= s1_in_rect;
            r1_dx      <= axis_excess(s1_cx, s1_l2, s1_r2, s1_c2);
            r1_dy      <= axis_excess(s1_cy, s1_t2, s1_b2, s1_c2);
            r1_wd      <= s1_wd;
            for (int i = 0; i < 3; i++) begin
                r1_sa[i] <= {8'd0, fill_src[i]} * {8'd0, fill_a};
            end
            r1_d[0] <= i_dest_red;
            r1_d[1] <= i_dest_green;
            r1_d[2] <= i_dest_blue;
            r1_da   <= i_dest_alpha;

            // Stage 2: squares, weighted numerator terms and the denominator.
            r2_valid   <= r1_valid;
            r2_in_rect <= r1_in_rect;
            r2_dx2     <= {{EXC_W{1'b0}}, r1_dx} * {{EXC_W{1'b0}}, r1_dx};
            r2_dy2     <= {{EXC_W{1'b0}}, r1_dy} * {{EXC_W{1'b0}}, r1_dy};
            r2_c2sq    <= {{EXC_W{1'b0}}, s2_c2} * {{EXC_W{1'b0}}, s2_c2};
            for (int i = 0; i < 3; i++) begin
                r2_num_s[i] <= {r1_sa[i], 8'd0} - {8'd0, r1_sa[i]};
                r2_num_d[i] <= {16'd0, r1_d[i]} * {8'd0, r1_wd};
                r2_d[i]     <= r1_d[i];
            end
            r2_den <= ({fill_a, 8'd0} - {8'd0, fill_a}) + r1_wd;
            r2_da  <= r1_da;

            // Stage 3: coverage decision, full numerators and the result alpha.
            r3_valid <= r2_valid;
            r3_cov   <= s3_cov;
            r3_pass  <= !s3_cov || (fill_a == 8'd0);
            for (int i = 0; i < 3; i++) begin
                r3_num[i] <= r2_num_s[i] + r2_num_d[i];
                r3_d[i]   <= r2_d[i];
            end
            r3_den   <= r2_den;
            r3_alpha <= s3_aprod[RECIP_SHIFT +: CH_W];
            r3_da    <= r2_da;

            // Side line that runs beside the divider lanes.
            r_side[0].valid  <= r3_valid;
            r_side[0].cov    <= r3_cov;
            r_side[0].pass   <= r3_pass;
            r_side[0].dst[0] <= r3_d[0];
            r_side[0].dst[1] <= r3_d[1];
            r_side[0].dst[2] <= r3_d[2];
            r_side[0].da     <= r3_da;
            r_side[0].alpha  <= r3_alpha;
            for (int k = 1; k < DIV_QUO_W; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    logic [DIV_QUO_W-1:0] quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_lane
        rrfb_divider u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (r3_num[i]),
            .i_den (r3_den),
            .o_quo (quo[i])
        );
    end

    // Output register: pass the destination through or take the blended word.
    t_side           side_last;
    logic [CH_W-1:0] r_out_red, r_out_green, r_out_blue, r_out_alpha;
    logic            r_out_cov;

    assign side_last = r_side[DIV_QUO_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= side_last.valid;
            r_out_cov   <= side_last.cov;
            if (side_last.pass) begin
                r_out_red   <= side_last.dst[0];
                r_out_green <= side_last.dst[1];
                r_out_blue  <= side_last.dst[2];
                r_out_alpha <= side_last.da;
            end else begin
                r_out_red   <= quo[0];
                r_out_green <= quo[1];
                r_out_blue  <= quo[2];
                r_out_alpha <= side_last.alpha;
            end
        end
    end

    assign o_valid     = r_out_valid;
    assign o_out_red   = r_out_red;
    assign o_out_green = r_out_green;
    assign o_out_blue  = r_out_blue;
    assign o_out_alpha = r_out_alpha;
    assign o_covered   = r_out_cov;

    // A word moves one stage on every cycle that the output is not held.
    a_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall |=> (r2_valid == $past(r1_valid)))
        else $error("pipeline valid bit did not advance");

    // Blending over a pixel never lowers its alpha.
    a_alpha_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (side_last.valid && side_last.cov) |-> (side_last.alpha >= side_last.da))
        else $error("blended alpha below destination alpha");

    // A blended red channel lies between the fill and destination values.
    a_red_between: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (side_last.valid && !side_last.pass) |->
        ((quo[0] >= fill_src[0]) || (quo[0] >= side_last.dst[0])) &&
        ((quo[0] <= fill_src[0]) || (quo[0] <= side_last.dst[0])))
        else $error("blended red outside its source range");

endmodule

### test/tb.sv
// Self-checking testbench for the rounded rectangle coverage test and over blend pipeline.
`timescale 1ns / 1ps

module tb;
    import rrfb_pkg::*;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       covered;
    } pixel_word_t;

    // Mirrors the configuration registers and holds the pixels still owed by the block.
    class pixel_blend_board;
        int          left;
        int          top;
        int          width;
        int          height;
        int          radius;
        logic [31:0] color;
        pixel_word_t owed_pixels[$];
        int          errors;

        function new();
            left   = 0;
            top    = 0;
            width  = 0;
            height = 0;
            radius = 0;
            color  = '0;
            errors = 0;
        endfunction

        function void set_reg(t_cfg_idx idx, logic [31:0] v);
            case (idx)
                CFG_RECT_LEFT:     left   = int'($signed(v[12:0]));
                CFG_RECT_TOP:      top    = int'($signed(v[12:0]));
                CFG_RECT_WIDTH:    width  = int'(v[12:0]);
                CFG_RECT_HEIGHT:   height = int'(v[12:0]);
                CFG_CORNER_RADIUS: radius = int'(v[11:0]);
                CFG_FILL_COLOR:    color  = v;
                default: ;
            endcase
        endfunction

        // Distance of a doubled coordinate beyond the straight part of one axis.
        function int corner_excess(int c, int lo, int hi, int c2);
            if (c < lo + c2) return lo + c2 - c;
            if (c > hi - c2) return c - (hi - c2);
            return 0;
        endfunction

        function bit centre_covered(int px, int py);
            int cx, cy, l2, r2, t2, b2, c2;
            longint dx, dy;
            cx = 2 * px + 1;
            cy = 2 * py + 1;
            l2 = 2 * left;
            r2 = 2 * (left + width);
            t2 = 2 * top;
            b2 = 2 * (top + height);
            c2 = 2 * radius;
            if (cx < l2 || cx >= r2 || cy < t2 || cy >= b2) return 1'b0;
            if (c2 == 0) return 1'b1;
            dx = corner_excess(cx, l2, r2, c2);
            dy = corner_excess(cy, t2, b2, c2);
            if (dx == 0 && dy == 0) return 1'b1;
            return (dx * dx + dy * dy) <= longint'(c2) * c2;
        endfunction

        function int mix(int s, int d, int a, int wd, int den);
            return (255 * s * a + d * wd) / den;
        endfunction

        function void note_pixel(int px, int py, pixel_word_t dst);
            pixel_word_t res;
            int a, wd, den;
            res = dst;
            res.covered = centre_covered(px, py);
            a = int'(color[7:0]);
            if (res.covered && a == 255) begin
                res.red   = color[31:24];
                res.green = color[23:16];
                res.blue  = color[15:8];
                res.alpha = 8'hFF;
            end else if (res.covered && a != 0) begin
                wd  = int'(dst.alpha) * (255 - a);
                den = 255 * a + wd;
                res.red   = 8'(mix(int'(color[31:24]), int'(dst.red), a, wd, den));
                res.green = 8'(mix(int'(color[23:16]), int'(dst.green), a, wd, den));
                res.blue  = 8'(mix(int'(color[15:8]), int'(dst.blue), a, wd, den));
                res.alpha = 8'(den / 255);
            end
            owed_pixels.push_back(res);
        endfunction

        function void check_field(string name, int want, int got);
            if (want != got) begin
                $error("%s expected %0d actual %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(pixel_word_t got);
            pixel_word_t want;
            if (owed_pixels.size() == 0) begin
                $error("result word arrived with no pixel pending");
                errors++;
                return;
            end
            want = owed_pixels.pop_front();
            check_field("out_red", want.red, got.red);
            check_field("out_green", want.green, got.green);
            check_field("out_blue", want.blue, got.blue);
            check_field("out_alpha", want.alpha, got.alpha);
            check_field("covered", want.covered, got.covered);
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_stall;
    logic [11:0]           i_pixel_x;
    logic [11:0]           i_pixel_y;
    logic [CH_W-1:0]       i_dest_red;
    logic [CH_W-1:0]       i_dest_green;
    logic [CH_W-1:0]       i_dest_blue;
    logic [CH_W-1:0]       i_dest_alpha;
    logic                  o_valid;
    logic                  i_stall;
    logic [CH_W-1:0]       o_out_red;
    logic [CH_W-1:0]       o_out_green;
    logic [CH_W-1:0]       o_out_blue;
    logic [CH_W-1:0]       o_out_alpha;
    logic                  o_covered;

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    pixel_blend_board board = new();

    rounded_rect_fill_blend dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_dest_red   (i_dest_red),
        .i_dest_green (i_dest_green),
        .i_dest_blue  (i_dest_blue),
        .i_dest_alpha (i_dest_alpha),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_out_red    (o_out_red),
        .o_out_green  (o_out_green),
        .o_out_blue   (o_out_blue),
        .o_out_alpha  (o_out_alpha),
        .o_covered    (o_covered)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                board.note_pixel(int'(i_pixel_x), int'(i_pixel_y),
                                 {i_dest_red, i_dest_green, i_dest_blue, i_dest_alpha, 1'b0});
            end
            if (o_valid && !i_stall) begin
                board.check_pixel({o_out_red, o_out_green, o_out_blue, o_out_alpha, o_covered});
            end
        end
    end

    // The receiver stalls at random, or for a whole stretch while hold_left counts down.
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_stall = 1'b1;
                hold_left--;
            end else begin
                i_stall = ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic send_pixel(int x, int y, int r, int g, int b, int a);
        logic [31:0] xv, yv, rv, gv, bv, av;
        xv = x;
        yv = y;
        rv = r;
        gv = g;
        bv = b;
        av = a;
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_pixel_x    = xv[11:0];
        i_pixel_y    = yv[11:0];
        i_dest_red   = rv[7:0];
        i_dest_green = gv[7:0];
        i_dest_blue  = bv[7:0];
        i_dest_alpha = av[7:0];
        i_valid      = 1'b1;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [31:0] v);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_reg(idx, v);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_drained();
        int n;
        n = 0;
        while (board.owed_pixels.size() != 0 && n < 20000) begin
            @(negedge i_clk);
            n++;
        end
        repeat (16) @(negedge i_clk);
    endtask

    task automatic apply_setting(int l, int t, int w, int h, int r, logic [31:0] c);
        logic [31:0] lv, tv, wv, hv, rv;
        lv = l;
        tv = t;
        wv = w;
        hv = h;
        rv = r;
        wait_drained();
        write_reg(CFG_RECT_LEFT, lv & 32'h1FFF);
        write_reg(CFG_RECT_TOP, tv & 32'h1FFF);
        write_reg(CFG_RECT_WIDTH, wv & 32'h1FFF);
        write_reg(CFG_RECT_HEIGHT, hv & 32'h1FFF);
        write_reg(CFG_CORNER_RADIUS, rv & 32'hFFF);
        write_reg(CFG_FILL_COLOR, c);
    endtask

    task automatic random_setting();
        int l, t, w, h, r;
        logic [31:0] c;
        w = $urandom_range(0, 80);
        h = $urandom_range(0, 80);
        l = int'($urandom_range(0, 4100)) - 100;
        t = int'($urandom_range(0, 4100)) - 100;
        if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 4095);
        end else begin
            r = $urandom_range(0, (w > h ? w : h) / 2 + 2);
        end
        c = $urandom;
        case ($urandom_range(0, 5))
            0: c[7:0] = 8'h00;
            1: c[7:0] = 8'hFF;
            default: ;
        endcase
        apply_setting(l, t, w, h, r, c);
    endtask

    function automatic int clamp_coord(int v);
        if (v < 0) return 0;
        if (v > 4095) return 4095;
        return v;
    endfunction

    function automatic int random_channel();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Most pixels land on or just around the rectangle, the rest anywhere on the grid.
    task automatic random_pixels(int count);
        int x, y;
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 3) != 0) begin
                x = clamp_coord(board.left + int'($urandom_range(0, board.width + 8)) - 4);
                y = clamp_coord(board.top + int'($urandom_range(0, board.height + 8)) - 4);
            end else begin
                x = $urandom_range(0, 4095);
                y = $urandom_range(0, 4095);
            end
            send_pixel(x, y, random_channel(), random_channel(), random_channel(),
                       random_channel());
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_pixel_x     = '0;
        i_pixel_y     = '0;
        i_dest_red    = '0;
        i_dest_green  = '0;
        i_dest_blue   = '0;
        i_dest_alpha  = '0;
        i_stall       = 1'b0;
        hold_left     = 0;
        send_idle_pct = 23;
        recv_idle_pct = 66;
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Rectangle 30 by 16 at (10, 20) with radius 5 and a half transparent fill.
        apply_setting(10, 20, 30, 16, 5, 32'hC040_8080);
        send_pixel(25, 27, 0, 0, 0, 0);
        send_pixel(25, 27, 255, 255, 255, 255);
        send_pixel(10, 20, 17, 34, 51, 200);
        send_pixel(12, 22, 90, 10, 200, 128);
        send_pixel(9, 27, 1, 2, 3, 4);
        send_pixel(10, 27, 255, 0, 255, 1);
        send_pixel(39, 27, 0, 255, 0, 254);
        send_pixel(40, 27, 9, 9, 9, 9);
        send_pixel(25, 19, 100, 100, 100, 100);
        send_pixel(25, 20, 100, 100, 100, 0);
        send_pixel(25, 35, 200, 50, 25, 255);
        send_pixel(25, 36, 7, 7, 7, 7);
        send_pixel(39, 35, 60, 70, 80, 90);
        send_pixel(0, 0, 0, 0, 0, 0);
        send_pixel(4095, 4095, 255, 255, 255, 255);
        // A fully transparent fill leaves covered pixels alone.
        apply_setting(10, 20, 30, 16, 5, 32'h1234_5600);
        send_pixel(25, 27, 11, 22, 33, 44);
        send_pixel(4095, 0, 200, 100, 50, 25);
        // An opaque fill replaces the pixel outright.
        apply_setting(10, 20, 30, 16, 5, 32'hA5B6_C7FF);
        send_pixel(25, 27, 11, 22, 33, 44);
        send_pixel(0, 4095, 1, 1, 1, 0);
        // The radius exceeds half of both sides and is used unclamped.
        apply_setting(10, 20, 30, 16, 20, 32'h3366_9901);
        send_pixel(25, 27, 255, 128, 0, 77);
        send_pixel(11, 28, 40, 50, 60, 70);
        send_pixel(25, 21, 40, 50, 60, 255);
        // Widest rectangle from the most negative corner with the largest radius.
        apply_setting(-4096, -4096, 8191, 8191, 4095, 32'hFFFF_FF7F);
        send_pixel(0, 0, 10, 20, 30, 40);
        send_pixel(4095, 4095, 250, 240, 230, 220);

        for (int mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 23;
                    recv_idle_pct = 66;
                end
                1: begin
                    send_idle_pct = 66;
                    recv_idle_pct = 23;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int s = 0; s < 6; s++) begin
                if (s == 0) begin
                    case (mode)
                        0: apply_setting(4095, 4095, 4096, 4096, 2048, $urandom);
                        1: apply_setting(0, 0, 0, 0, 0, $urandom);
                        default: apply_setting(0, 0, 4096, 4096, 2048, 32'h40C0_2080);
                    endcase
                end else begin
                    random_setting();
                end
                if (mode == 2 && s == 1) begin
                    hold_left = 120;
                end
                random_pixels(78);
            end
        end

        wait_drained();
        if (board.errors == 0 && board.owed_pixels.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (board.owed_pixels.size() != 0) begin
                $error("%0d expected pixels never arrived", board.owed_pixels.size());
            end
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
design/rrfb_pkg.sv
design/rrfb_divider.sv
design/rounded_rect_fill_blend.sv
test/tb.sv
